### rtl/fmbp_pkg.sv
// Shared types and constants of the framed message byte parser.
`default_nettype none
package fmbp_pkg;

  localparam int BYTE_W            = 8;
  localparam int MAC_W             = 48;
  localparam int PAYLOAD_W         = 40;
  localparam int PAYLOAD_BYTES_DEF = 5;
  localparam int CFG_INDEX_W       = 1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hBB;

  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 1'd1;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_SEQ   = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_NEW  = 2'd1,
    ST_DUP  = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [BYTE_W-1:0]      seq_number;
    logic [BYTE_W-1:0]      msg_type;
    logic [PAYLOAD_W-1:0]   payload;
    logic [MAC_W-1:0]       frame_source;
  } result_t;

endpackage
`default_nettype wire

### rtl/fmbp_if.sv
// Valid/ready channel interfaces for the parser's byte input and result output.
`default_nettype none
interface fmbp_in_if import fmbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic [MAC_W-1:0]  source_mac;

  modport source (output valid, output rx_byte, output source_mac, input ready);
  modport sink   (input valid, input rx_byte, input source_mac, output ready);
endinterface

interface fmbp_out_if import fmbp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [BYTE_W-1:0]    seq_number;
  logic [BYTE_W-1:0]    msg_type;
  logic [PAYLOAD_W-1:0] payload;
  logic [MAC_W-1:0]     frame_source;

  modport source (output valid, output status, output seq_number, output msg_type,
                  output payload, output frame_source, input ready);
  modport sink   (input valid, input status, input seq_number, input msg_type,
                  input payload, input frame_source, output ready);
endinterface
`default_nettype wire

### rtl/framed_message_byte_parser.sv
// Framed message byte parser: top level with frame state machine and output stage.
//
// Each request on in_ch carries one received byte and the sender address of its
// packet. Every accepted byte produces exactly one result request on out_ch; its
// status is zero except on the check byte of a frame, where it reports a new
// frame, a duplicate sequence number or a failed check, with the frame's fields.
// The sync byte values are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while idle, as the block does not enforce it. One byte is
// accepted every cycle while in_ch ready is high. Each result is registered in the
// output register, which is backed by a skid register, so a byte is still taken
// while one result waits. Only when both are full does in_ch ready drop, until
// out_ch takes a result. Synchronous reset restores the sync values, waits for a
// first sync byte, forgets the last sequence number and empties the output stage.
`default_nettype none
module framed_message_byte_parser import fmbp_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  fmbp_in_if.sink                     in_ch,
  fmbp_out_if.source                  out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]      cfg_wdata
);

  localparam int CNT_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int NPACK  = (PAYLOAD_BYTES < PAYLOAD_W / BYTE_W) ? PAYLOAD_BYTES
                                                               : PAYLOAD_W / BYTE_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

  logic [BYTE_W-1:0] sync_first_r, sync_second_r;
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] held_seq_r, held_seq_nxt;
  logic [BYTE_W-1:0] held_type_r, held_type_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] last_seq_r, last_seq_nxt;
  logic              last_seq_valid_r, last_seq_valid_nxt;
  logic [BYTE_W-1:0] store_r [PAYLOAD_BYTES];

  result_t           res, out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              acc, take;
  logic [BYTE_W-1:0] b;
  logic [PAYLOAD_W-1:0] packed_pl;
  logic              check_ok;

  assign b        = in_ch.rx_byte;
  assign in_ch.ready = !skid_valid_r;
  assign acc      = in_ch.valid && !skid_valid_r;
  assign take     = out_valid_r && out_ch.ready;
  assign check_ok = (xor_r == b);

  always_comb begin
    packed_pl = '0;
    for (int i = 0; i < NPACK; i++) begin
      packed_pl[BYTE_W*i +: BYTE_W] = store_r[i];
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = PH_SYNC1;
    unique case (phase_r)
      PH_SYNC2: phase_nxt = (b == sync_second_r) ? PH_SEQ
                          : ((b == sync_first_r) ? PH_SYNC2 : PH_SYNC1);
      PH_SEQ:   phase_nxt = PH_TYPE;
      PH_TYPE:  phase_nxt = PH_DATA;
      PH_DATA:  phase_nxt = (cnt_r == CNT_LAST) ? PH_CHECK : PH_DATA;
      PH_CHECK: phase_nxt = check_ok ? PH_SYNC1
                          : ((b == sync_first_r) ? PH_SYNC2 : PH_SYNC1);
      default:  phase_nxt = (b == sync_first_r) ? PH_SYNC2 : PH_SYNC1;
    endcase
  end

  // Datapath and result.
  always_comb begin
    xor_nxt            = xor_r;
    held_seq_nxt       = held_seq_r;
    held_type_nxt      = held_type_r;
    cnt_nxt            = cnt_r;
    last_seq_nxt       = last_seq_r;
    last_seq_valid_nxt = last_seq_valid_r;
    res                = '0;
    unique case (phase_r)
      PH_SYNC2: xor_nxt = (b == sync_second_r) ? (xor_r ^ b) : b;
      PH_SEQ: begin
        xor_nxt      = xor_r ^ b;
        held_seq_nxt = b;
      end
      PH_TYPE: begin
        xor_nxt       = xor_r ^ b;
        held_type_nxt = b;
        cnt_nxt       = '0;
      end
      PH_DATA: begin
        xor_nxt = xor_r ^ b;
        if (cnt_r != CNT_LAST) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      PH_CHECK: begin
        res.seq_number   = held_seq_r;
        res.msg_type     = held_type_r;
        res.payload      = packed_pl;
        res.frame_source = in_ch.source_mac;
        if (!check_ok) begin
          res.status = ST_FAIL;
          xor_nxt    = b;
        end else if (!last_seq_valid_r || held_seq_r != last_seq_r) begin
          res.status         = ST_NEW;
          last_seq_nxt       = held_seq_r;
          last_seq_valid_nxt = 1'b1;
        end else begin
          res.status = ST_DUP;
        end
      end
      default: xor_nxt = b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r     <= SYNC_FIRST_RST;
      sync_second_r    <= SYNC_SECOND_RST;
      phase_r          <= PH_SYNC1;
      xor_r            <= '0;
      held_seq_r       <= '0;
      held_type_r      <= '0;
      cnt_r            <= '0;
      last_seq_r       <= '0;
      last_seq_valid_r <= 1'b0;
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
          CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc) begin
        phase_r          <= phase_nxt;
        xor_r            <= xor_nxt;
        held_seq_r       <= held_seq_nxt;
        held_type_r      <= held_type_nxt;
        cnt_r            <= cnt_nxt;
        last_seq_r       <= last_seq_nxt;
        last_seq_valid_r <= last_seq_valid_nxt;
      end
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= !take;
      end else begin
        out_valid_r  <= acc || (out_valid_r && !take);
        skid_valid_r <= acc && out_valid_r && !take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && phase_r == PH_DATA) begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        if (cnt_r == CNT_W'(i)) begin
          store_r[i] <= b;
        end
      end
    end
    if (skid_valid_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (acc) begin
      if (!out_valid_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.seq_number   = out_r.seq_number;
  assign out_ch.msg_type     = out_r.msg_type;
  assign out_ch.payload      = out_r.payload;
  assign out_ch.frame_source = out_r.frame_source;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_type_starts_data: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == PH_TYPE) |=> (phase_r == PH_DATA && cnt_r == '0))
    else $error("type byte did not start the payload at its first byte");

  a_new_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.status == ST_NEW) |=> (last_seq_valid_r && last_seq_r == $past(held_seq_r)))
    else $error("new frame did not record its sequence number");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_valid_r && acc && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("result lost while the output was stalled");

endmodule
`default_nettype wire

### bench/fmbp_result_check.sv
// Result checker for the framed message byte parser: predicts each result and compares it.
`timescale 1ns / 100ps
module fmbp_result_check import fmbp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  fmbp_in_if                     in_mon,
  fmbp_out_if                    out_mon,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_wdata,
  output int                     mismatch_count,
  output int                     awaited_count
);

  localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;

  logic [BYTE_W-1:0] sync_a;
  logic [BYTE_W-1:0] sync_b;
  phase_t            phase;
  logic [BYTE_W-1:0] xor_acc;
  logic [BYTE_W-1:0] seq_hold;
  logic [BYTE_W-1:0] type_hold;
  logic [BYTE_W-1:0] payload_bytes [PAYLOAD_BYTES];
  logic [2:0]        byte_idx;
  logic [BYTE_W-1:0] last_seq;
  logic              last_seq_seen;

  result_t awaited_results [$];
  int      errors;

  function automatic void restart_hunt(input logic [BYTE_W-1:0] b);
    xor_acc = b;
    phase = (b == sync_a) ? PH_SYNC2 : PH_SYNC1;
  endfunction

  function automatic result_t parse_next_byte(input logic [BYTE_W-1:0] b,
                                              input logic [MAC_W-1:0] mac);
    result_t r;
    r = '0;
    case (phase)
      PH_SYNC2: begin
        if (b == sync_b) begin
          xor_acc ^= b;
          phase = PH_SEQ;
        end else begin
          restart_hunt(b);
        end
      end
      PH_SEQ: begin
        xor_acc ^= b;
        seq_hold = b;
        phase = PH_TYPE;
      end
      PH_TYPE: begin
        xor_acc ^= b;
        type_hold = b;
        byte_idx = '0;
        phase = PH_DATA;
      end
      PH_DATA: begin
        xor_acc ^= b;
        payload_bytes[byte_idx] = b;
        if (int'(byte_idx) + 1 >= PAYLOAD_BYTES) begin
          phase = PH_CHECK;
        end else begin
          byte_idx = byte_idx + 3'd1;
        end
      end
      PH_CHECK: begin
        r.seq_number = seq_hold;
        r.msg_type = type_hold;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          r.payload[8*i +: 8] = payload_bytes[i];
        end
        r.frame_source = mac;
        if (xor_acc == b) begin
          phase = PH_SYNC1;
          if (!last_seq_seen || seq_hold != last_seq) begin
            last_seq = seq_hold;
            last_seq_seen = 1'b1;
            r.status = ST_NEW;
          end else begin
            r.status = ST_DUP;
          end
        end else begin
          r.status = ST_FAIL;
          restart_hunt(b);
        end
      end
      default: begin
        restart_hunt(b);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      sync_a = SYNC_FIRST_RST;
      sync_b = SYNC_SECOND_RST;
      phase = PH_SYNC1;
      xor_acc = '0;
      seq_hold = '0;
      type_hold = '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        payload_bytes[i] = '0;
      end
      byte_idx = '0;
      last_seq = '0;
      last_seq_seen = 1'b0;
      awaited_results.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SYNC_FIRST) begin
          sync_a = cfg_wdata;
        end else if (cfg_index == CFG_SYNC_SECOND) begin
          sync_b = cfg_wdata;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_results.push_back(parse_next_byte(in_mon.rx_byte, in_mon.source_mac));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.status = out_mon.status;
        got.seq_number = out_mon.seq_number;
        got.msg_type = out_mon.msg_type;
        got.payload = out_mon.payload;
        got.frame_source = out_mon.frame_source;
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result: status %0d seq %0h type %0h payload %0h src %0h",
                     $time, got.status, got.seq_number, got.msg_type, got.payload,
                     got.frame_source);
          end
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.seq_number !== want.seq_number ||
              got.msg_type !== want.msg_type || got.payload !== want.payload ||
              got.frame_source !== want.frame_source) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected status %0d seq %0h type %0h payload %0h src %0h",
                       want.status, want.seq_number, want.msg_type, want.payload,
                       want.frame_source);
              $display("  actual   status %0d seq %0h type %0h payload %0h src %0h",
                       got.status, got.seq_number, got.msg_type, got.payload,
                       got.frame_source);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    awaited_count <= awaited_results.size();
  end

endmodule

### bench/tb_top.sv
// Testbench top for the framed message byte parser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import fmbp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 305;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]      cfg_wdata;
  int                     mismatch_count;
  int                     awaited_count;

  int                idle_pct;
  int                stall_pct;
  int                bytes_sent;
  int                cycles;
  logic [BYTE_W-1:0] sync1;
  logic [BYTE_W-1:0] sync2;
  logic [BYTE_W-1:0] last_seq_sent;

  fmbp_in_if  in_ch ();
  fmbp_out_if out_ch ();

  framed_message_byte_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fmbp_result_check result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [MAC_W-1:0] pick_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return w[MAC_W-1:0];
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [MAC_W-1:0] mac);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.source_mac <= mac;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input bit lead, input logic [BYTE_W-1:0] seq,
                            input logic [BYTE_W-1:0] typ, input logic [PAYLOAD_W-1:0] pl,
                            input logic [BYTE_W-1:0] flip);
    logic [BYTE_W-1:0] chk;
    chk = sync1 ^ sync2 ^ seq ^ typ;
    for (int i = 0; i < PAYLOAD_BYTES_DEF; i++) begin
      chk ^= pl[8*i +: 8];
    end
    if (lead) send_byte(sync1, pick_mac());
    send_byte(sync2, pick_mac());
    send_byte(seq, pick_mac());
    send_byte(typ, pick_mac());
    for (int i = 0; i < PAYLOAD_BYTES_DEF; i++) begin
      send_byte(pl[8*i +: 8], pick_mac());
    end
    send_byte(chk ^ flip, pick_mac());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sync_regs(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= s1;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_wdata <= s2;
    @(posedge clk);
    cfg_we <= 1'b0;
    sync1 = s1;
    sync2 = s2;
  endtask

  task automatic run_phase(input int idle, input int stall,
                           input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2);
    int   stop_at;
    int   pause_at;
    bit   paused;
    int   pick;
    logic [BYTE_W-1:0] seq;
    logic [BYTE_W-1:0] flip;
    logic [63:0]       w;
    drain();
    write_sync_regs(s1, s2);
    idle_pct = idle;
    stall_pct <= stall;
    stop_at = bytes_sent + PHASE_BYTES;
    pause_at = bytes_sent + PHASE_BYTES / 2;
    paused = 1'b0;
    while (bytes_sent < stop_at) begin
      if (!paused && bytes_sent >= pause_at) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 65) begin
        seq = ($urandom_range(3) == 0) ? last_seq_sent : 8'($urandom);
        flip = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
        w = {$urandom, $urandom};
        send_frame(1'b1, seq, 8'($urandom), w[PAYLOAD_W-1:0], flip);
        if (flip == 8'h00) last_seq_sent = seq;
      end else if (pick < 75) begin
        send_byte(sync1, pick_mac());
        send_byte(8'($urandom), pick_mac());
      end else if (pick < 85) begin
        send_byte(sync1, pick_mac());
        send_byte(sync2, pick_mac());
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom), pick_mac());
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom), pick_mac());
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    in_ch.source_mac <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_wdata <= '0;
    idle_pct = 0;
    stall_pct <= 0;
    bytes_sent = 0;
    sync1 = SYNC_FIRST_RST;
    sync2 = SYNC_SECOND_RST;
    last_seq_sent = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // A stray byte, then a first sync whose follower is another first sync byte.
    send_byte(8'h55, '0);
    send_byte(SYNC_FIRST_RST, '1);
    // The first frame after reset is new even though its sequence number is zero.
    send_frame(1'b1, 8'h00, 8'hFF, '1, 8'h00);
    // A failed check whose check byte is itself a first sync byte starts the next frame.
    send_frame(1'b1, 8'h22, 8'h33, '0, 8'hAA);
    send_frame(1'b0, 8'h00, 8'h00, '0, 8'h00);

    run_phase(0, 0, 8'h00, 8'hFF);
    run_phase(75, 0, 8'hFF, 8'h00);
    run_phase(0, 75, 8'h5A, 8'h5A);
    run_phase(14, 14, SYNC_FIRST_RST, SYNC_SECOND_RST);
    drain();

    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
